// ----- rtl/rmte_pkg.sv -----
// ----------------------------------------------------------------------------
// rmte_pkg
// Shared widths, latencies and the CORDIC angle table for the rotation
// matrix to ZYX Euler angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmte_pkg;

  // Matrix entries: signed Q2.16
  localparam int MAT_W    = 18;
  // atan2 operands: one extra bit so that a negated entry or sy fits
  localparam int OP_W     = MAT_W + 1;

  // Integer square root of r00^2 + r10^2
  localparam int SQ_W     = 2 * MAT_W;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQRT_LAT = 2 + ROOT_W;  // multiply, sum, one stage per root bit

  // Vectoring CORDIC
  localparam int CORDIC_STAGES = 16;
  localparam int ANG_LEN       = 24;
  localparam int NST      = (CORDIC_STAGES < ANG_LEN) ? CORDIC_STAGES : ANG_LEN;
  localparam int SCALE_SH = 24;            // operands carry 24 guard bits
  localparam int CW       = OP_W + SCALE_SH + 3;  // room for the CORDIC gain
  localparam int ZW       = 32;            // 2^31 = pi
  localparam int ANG_W    = 16;
  localparam int CO_LAT   = NST + 2;       // prep, stages, rounding

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ZW-1:0] Z_ROUND   = 32'h0000_8000;

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [ZW-1:0] ANG_TAB [ANG_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Configuration
  localparam int              THR_W     = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd1;
  localparam int              APB_AW    = 3;
  localparam int              APB_DW    = 32;
  localparam logic            REG_THR   = 1'b0;  // word index of the threshold

  // Total depth, input register to output register
  localparam int TOT_LAT = SQRT_LAT + CO_LAT + 3;

  typedef struct packed {
    logic signed [MAT_W-1:0] r22;
    logic signed [MAT_W-1:0] r21;
    logic signed [MAT_W-1:0] r20;
    logic signed [MAT_W-1:0] r12;
    logic signed [MAT_W-1:0] r11;
    logic signed [MAT_W-1:0] r10;
    logic signed [MAT_W-1:0] r00;
  } mat_t;

endpackage

`default_nettype wire

// ----- rtl/rmte_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmte_sqrt
// Pipelined floor(sqrt(r00^2 + r10^2)), one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmte_sqrt (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rmte_pkg::MAT_W-1:0]    r00,
  input  logic signed [rmte_pkg::MAT_W-1:0]    r10,
  output logic        [rmte_pkg::ROOT_W-1:0]   sy
);
  import rmte_pkg::*;

  logic signed [SQ_W-1:0] p0_r, p1_r;
  logic [REM_W-1:0]  rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [SQ_W-1:0]   rad_r  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r      <= r00 * r00;
      p1_r      <= r10 * r10;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= SQ_W'(unsigned'(p0_r)) + SQ_W'(unsigned'(p1_r));
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;

    assign cur   = {rem_r[k][REM_W-3:0], rad_r[k][SQ_W-1 -: 2]};
    assign trial = REM_W'({root_r[k], 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1] <= {rad_r[k][SQ_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_r[k+1]  <= cur - trial;
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= cur;
          root_r[k+1] <= {root_r[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign sy = root_r[ROOT_W];

endmodule

`default_nettype wire

// ----- rtl/rmte_cordic.sv -----
// ----------------------------------------------------------------------------
// rmte_cordic
// Pipelined vectoring CORDIC atan2(y, x) giving a 16-bit binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmte_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rmte_pkg::OP_W-1:0]    y,
  input  logic signed [rmte_pkg::OP_W-1:0]    x,
  output logic signed [rmte_pkg::ANG_W-1:0]   ang
);
  import rmte_pkg::*;

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] x_r [NST+1];
  logic signed [CW-1:0] y_r [NST+1];
  logic [ZW-1:0]        z_r [NST+1];
  logic                 zero_r [NST+1];
  logic [ZW-1:0]        z_rnd;
  logic signed [ANG_W-1:0] ang_r;

  assign xe = {{(CW-OP_W-SCALE_SH){x[OP_W-1]}}, x, {SCALE_SH{1'b0}}};
  assign ye = {{(CW-OP_W-SCALE_SH){y[OP_W-1]}}, y, {SCALE_SH{1'b0}}};

  // Left half plane: rotate by pi first
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x == '0) && (y == '0);
      if (x[OP_W-1]) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= HALF_TURN;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ANG_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ANG_TAB[i];
        end
      end
    end
  end

  assign z_rnd = z_r[NST] + Z_ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zero_r[NST] ? '0 : signed'(z_rnd[ZW-1 -: ANG_W]);
    end
  end

  assign ang = ang_r;

endmodule

`default_nettype wire

// ----- rtl/rotation_matrix_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles
// Rotation matrix (Q2.16) to ZYX roll / pitch / yaw binary angles.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake        | Payload
// --------+-----+------------------+-----------------------------------------
// in_     | in  | tvalid / tready  | tdata: r00 r10 r11 r12 r20 r21 r22, 18b each
// out_    | out | tvalid / tready  | tdata: roll pitch yaw 16b; tuser: singular
// cfg_    | in  | APB psel/penable | 0x0: singular_threshold, 17b
//
// One item per cycle while out_tready does not stall the pipe. Stages in order:
// input register, 20-deep square root pipe, operand select, 18-deep atan2
// pipe, output register. The square root must finish before the pitch atan2
// and the singular decision, which sets the depth.
// Reset (synchronous, active low) clears the valid bits, threshold goes to 1.
// A stall on out_tready freezes the whole pipe; in_tready follows it.
//
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler_angles (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [127:0]                    in_tdata,   // r00, r10, r11, r12, r20, r21, r22, pad
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // roll, pitch, yaw
  output logic [0:0]                      out_tuser,  // singular
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rmte_pkg::APB_AW-1:0]     cfg_paddr,
  input  logic [rmte_pkg::APB_DW-1:0]     cfg_pwdata,
  output logic [rmte_pkg::APB_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import rmte_pkg::*;

  logic             en;
  logic [THR_W-1:0] thr_r;

  // valid travels alongside the data, one bit per stage
  logic vld_r [TOT_LAT];

  mat_t m_r;
  mat_t md_r [SQRT_LAT];
  logic [ROOT_W-1:0] sy;

  // operand select stage
  logic                   sing_r;
  logic signed [OP_W-1:0] roll_y_r, roll_x_r;
  logic signed [OP_W-1:0] pitch_y_r, pitch_x_r;
  logic signed [OP_W-1:0] yaw_y_r, yaw_x_r;
  logic                   sd_r [CO_LAT];

  mat_t                   ms;
  logic                   sing;
  logic signed [ANG_W-1:0] roll_a, pitch_a, yaw_a;
  logic signed [ANG_W-1:0] roll_r, pitch_r, yaw_r;
  logic                   sing_out_r;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THR) ? APB_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_THR) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  // The output register frees whenever it is empty or being taken.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOT_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < TOT_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---------------- input register and matrix delay line ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= mat_t'({in_tdata[125:108], in_tdata[107:90], in_tdata[89:72],
                         in_tdata[71:54], in_tdata[53:36], in_tdata[35:18],
                         in_tdata[17:0]});
      md_r[0] <= m_r;
      for (int k = 1; k < SQRT_LAT; k++) md_r[k] <= md_r[k-1];
    end
  end

  rmte_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .r00 (m_r.r00),
    .r10 (m_r.r10),
    .sy  (sy)
  );

  // ---------------- operand select ----------------
  // Gimbal lock: roll from the second row, yaw fed a zero vector (reads 0).
  assign ms   = md_r[SQRT_LAT-1];
  assign sing = sy < ROOT_W'(thr_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r    <= sing;
      pitch_y_r <= -{ms.r20[MAT_W-1], ms.r20};
      pitch_x_r <= signed'({1'b0, sy});
      if (sing) begin
        roll_y_r <= -{ms.r12[MAT_W-1], ms.r12};
        roll_x_r <= {ms.r11[MAT_W-1], ms.r11};
        yaw_y_r  <= '0;
        yaw_x_r  <= '0;
      end else begin
        roll_y_r <= {ms.r21[MAT_W-1], ms.r21};
        roll_x_r <= {ms.r22[MAT_W-1], ms.r22};
        yaw_y_r  <= {ms.r10[MAT_W-1], ms.r10};
        yaw_x_r  <= {ms.r00[MAT_W-1], ms.r00};
      end
      sd_r[0] <= sing_r;
      for (int k = 1; k < CO_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // ---------------- three atan2 pipes ----------------
  rmte_cordic u_roll (
    .clk (clk), .en (en), .y (roll_y_r), .x (roll_x_r), .ang (roll_a)
  );

  rmte_cordic u_pitch (
    .clk (clk), .en (en), .y (pitch_y_r), .x (pitch_x_r), .ang (pitch_a)
  );

  rmte_cordic u_yaw (
    .clk (clk), .en (en), .y (yaw_y_r), .x (yaw_x_r), .ang (yaw_a)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r     <= roll_a;
      pitch_r    <= pitch_a;
      yaw_r      <= yaw_a;
      sing_out_r <= sd_r[CO_LAT-1];
    end
  end

  assign out_tvalid = vld_r[TOT_LAT-1];
  assign out_tdata  = {yaw_r, pitch_r, roll_r};
  assign out_tuser  = sing_out_r;

endmodule

`default_nettype wire
